// ===== design/b32d_pkg.sv =====
// Package for the base32 decoder: status codes, alphabet lookup, bit counts.
`default_nettype none
package b32d_pkg;

    localparam int unsigned CharWidth = 8;
    localparam int unsigned SymWidth  = 5;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned PosWidth  = 3;
    localparam int unsigned LeftWidth = 7;
    localparam int unsigned AccWidth  = LeftWidth + SymWidth;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_CHAR   = 2'd1,
        STATUS_BAD_LENGTH = 2'd2
    } status_t;

    typedef struct packed {
        logic                known;
        logic [SymWidth-1:0] value;
    } symbol_t;

    // Alphabet "eaosrnidlctumpbgyvqhfzjxkw765432", value = position in it
    function automatic symbol_t symbol_lookup(input logic [CharWidth-1:0] ch);
        symbol_t s;
        s.known = 1'b1;
        unique case (ch)
            8'h65:   s.value = 5'd0;   // e
            8'h61:   s.value = 5'd1;   // a
            8'h6f:   s.value = 5'd2;   // o
            8'h73:   s.value = 5'd3;   // s
            8'h72:   s.value = 5'd4;   // r
            8'h6e:   s.value = 5'd5;   // n
            8'h69:   s.value = 5'd6;   // i
            8'h64:   s.value = 5'd7;   // d
            8'h6c:   s.value = 5'd8;   // l
            8'h63:   s.value = 5'd9;   // c
            8'h74:   s.value = 5'd10;  // t
            8'h75:   s.value = 5'd11;  // u
            8'h6d:   s.value = 5'd12;  // m
            8'h70:   s.value = 5'd13;  // p
            8'h62:   s.value = 5'd14;  // b
            8'h67:   s.value = 5'd15;  // g
            8'h79:   s.value = 5'd16;  // y
            8'h76:   s.value = 5'd17;  // v
            8'h71:   s.value = 5'd18;  // q
            8'h68:   s.value = 5'd19;  // h
            8'h66:   s.value = 5'd20;  // f
            8'h7a:   s.value = 5'd21;  // z
            8'h6a:   s.value = 5'd22;  // j
            8'h78:   s.value = 5'd23;  // x
            8'h6b:   s.value = 5'd24;  // k
            8'h77:   s.value = 5'd25;  // w
            8'h37:   s.value = 5'd26;  // 7
            8'h36:   s.value = 5'd27;  // 6
            8'h35:   s.value = 5'd28;  // 5
            8'h34:   s.value = 5'd29;  // 4
            8'h33:   s.value = 5'd30;  // 3
            8'h32:   s.value = 5'd31;  // 2
            default:
            begin
                s.known = 1'b0;
                s.value = 5'd0;
            end
        endcase
        return s;
    endfunction

    // Bits held over before the next symbol: (5 * position) mod 8
    function automatic logic [2:0] held_bits(input logic [PosWidth-1:0] pos);
        logic [2:0] n;
        n = pos + {pos[0], 2'b00};
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== design/b32d_in_if.sv =====
// Character input channel: valid/ready with one encoded character.
`default_nettype none
interface b32d_in_if;
    logic                               valid;
    logic                               ready;
    logic [b32d_pkg::CharWidth-1:0]     char_code;
    logic                               end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== design/b32d_out_if.sv =====
// Byte output channel: valid/ready with decoded byte, status and last flag.
`default_nettype none
interface b32d_out_if;
    logic                               valid;
    logic                               ready;
    logic [b32d_pkg::ByteWidth-1:0]     data_byte;
    b32d_pkg::status_t                  status;
    logic                               last;

    modport source (output valid, output data_byte, output status, output last, input ready);
    modport sink   (input valid, input data_byte, input status, input last, output ready);
endinterface
`default_nettype wire

// ===== design/base32_decoder_custom_alphabet.sv =====
// Streaming base32 decoder, custom lower-case alphabet, unpadded input.
//
// One character is taken per cycle on in_ch unless stalled; the symbol lookup
// and bit packing sit between the input port and the output register. A byte
// appears on out_ch whenever eight bits have gathered and no unknown character
// has been seen; a character that completes no byte gives no transfer. The
// final character (end_of_text) always gives one transfer with last set: status
// 1 if any unknown character was seen in the stream, else status 2 if the
// stream length mod 8 is 1, 3 or 6, else status 0 with the last byte. Trailing
// bits are dropped. The output register frees in the cycle it is read, so input
// is stalled only while a result waits and out_ch.ready is low.
`default_nettype none
module base32_decoder_custom_alphabet
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    b32d_in_if.sink     in_ch,
    b32d_out_if.source  out_ch
);

    logic [b32d_pkg::LeftWidth-1:0] left_reg, left_next;
    logic [b32d_pkg::PosWidth-1:0]  pos_reg, pos_next;
    logic                           bad_reg, bad_next;

    logic                           out_valid_reg, out_valid_next;
    logic [b32d_pkg::ByteWidth-1:0] out_byte_reg, out_byte_next;
    b32d_pkg::status_t              out_status_reg, out_status_next;
    logic                           out_last_reg, out_last_next;

    logic                           accept;
    b32d_pkg::symbol_t              sym;
    logic [3:0]                     total;
    logic [2:0]                     rest;
    logic [b32d_pkg::AccWidth-1:0]  acc;
    logic [b32d_pkg::AccWidth-1:0]  shifted;
    logic [b32d_pkg::AccWidth-1:0]  keep_mask;
    logic                           got_byte;
    logic [b32d_pkg::PosWidth-1:0]  pos_inc;
    logic                           bad_now;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.data_byte = out_byte_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.last      = out_last_reg;

    always_comb
    begin
        sym       = b32d_pkg::symbol_lookup(in_ch.char_code);
        bad_now   = bad_reg || !sym.known;
        total     = {1'b0, b32d_pkg::held_bits(pos_reg)} + 4'd5;
        rest      = total[2:0];
        acc       = {left_reg, sym.value};
        shifted   = acc >> rest;
        keep_mask = (b32d_pkg::AccWidth'(1) << rest) - b32d_pkg::AccWidth'(1);
        got_byte  = !bad_now && total[3];
        pos_inc   = pos_reg + 3'd1;
    end

    always_comb
    begin
        left_next       = left_reg;
        pos_next        = pos_reg;
        bad_next        = bad_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (accept)
        begin
            pos_next = pos_inc;
            bad_next = bad_now;
            if (bad_now)
                left_next = '0;
            else if (total[3])
                left_next = b32d_pkg::LeftWidth'(acc & keep_mask);
            else
                left_next = acc[b32d_pkg::LeftWidth-1:0];

            if (in_ch.end_of_text)
            begin
                out_valid_next = 1'b1;
                out_last_next  = 1'b1;
                out_byte_next  = '0;
                if (bad_now)
                    out_status_next = b32d_pkg::STATUS_BAD_CHAR;
                else if (pos_inc inside {3'd1, 3'd3, 3'd6})
                    out_status_next = b32d_pkg::STATUS_BAD_LENGTH;
                else
                begin
                    out_status_next = b32d_pkg::STATUS_OK;
                    if (got_byte)
                        out_byte_next = shifted[b32d_pkg::ByteWidth-1:0];
                end
                // stream over: start afresh
                left_next = '0;
                pos_next  = '0;
                bad_next  = 1'b0;
            end
            else if (got_byte)
            begin
                out_valid_next  = 1'b1;
                out_last_next   = 1'b0;
                out_status_next = b32d_pkg::STATUS_OK;
                out_byte_next   = shifted[b32d_pkg::ByteWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            pos_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule
`default_nettype wire
